@@ hdl/pixel_temporal_lowpass_assert.svh @@
// ----------------------------------------------------------------------------
// pixel_temporal_lowpass_assert.svh
// Assertion macros for the temporal low-pass block, clocked on clk_i and
// held off while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef PIXEL_TEMPORAL_LOWPASS_ASSERT_SVH
`define PIXEL_TEMPORAL_LOWPASS_ASSERT_SVH

// same-cycle implication
`define PTL_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("temporal lowpass assertion failed");

// next-cycle implication
`define PTL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("temporal lowpass assertion failed");

`endif

@@ hdl/ptl_pkg.sv @@
// ----------------------------------------------------------------------------
// ptl_pkg
// Shared types, constants and coefficient table of the temporal low-pass.
// ----------------------------------------------------------------------------
package ptl_pkg;

  localparam int IdxW     = 20;
  localparam int IdxExtW  = 25;
  localparam int SampleW  = 8;
  localparam int StoreW   = 2 * SampleW;
  localparam int CutoffW  = 4;
  localparam int PAddrW   = 3;
  localparam int PDataW   = 32;
  localparam int TableLen = 11;
  localparam int DecW     = 24;

  localparam int FrameSamplesDef = 1048576;
  localparam int CoefFracBitsDef = 20;

  localparam logic [CutoffW-1:0] CutoffMax = CutoffW'(TableLen - 1);
  localparam logic [SampleW-1:0] SampleMax = '1;

  // register indexes (paddr[2])
  localparam logic RegEnable = 1'b0;
  localparam logic RegCutoff = 1'b1;

  localparam logic [63:0] DecScale = 64'd10000000;

  // feedforward b and feedback |a|, units of 1e-7
  localparam logic [DecW-1:0] FfDec [TableLen] = '{
    24'd1571, 24'd3141, 24'd15683, 24'd31318, 24'd154663, 24'd304687,
    24'd1367287, 24'd2452373, 24'd3375000, 24'd4208000, 24'd5000000
  };
  localparam logic [DecW-1:0] FbDec [TableLen] = '{
    24'd9996859, 24'd9993719, 24'd9968633, 24'd9937365, 24'd9690674,
    24'd9390625, 24'd7265425, 24'd5095254, 24'd3249000, 24'd1584000, 24'd0
  };

  typedef struct packed {
    logic               enable;
    logic [CutoffW-1:0] cutoff;
  } cfg_t;

  typedef struct packed {
    logic s1_valid;
    logic s2_valid;
    logic hazard;
    logic store_wr;
  } stat_t;

  // round half up to Q0.frac, evaluated at elaboration only
  function automatic logic [63:0] to_fixed(input logic [DecW-1:0] dec, input int frac);
    logic [63:0] scaled;
    scaled = {40'b0, dec} << frac;
    return (scaled + DecScale / 2) / DecScale;
  endfunction

  function automatic int addr_width(input int depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

endpackage

@@ hdl/ptl_in_if.sv @@
// ----------------------------------------------------------------------------
// ptl_in_if
// Sample request channel: pixel index, raw sample and prime flag.
// ----------------------------------------------------------------------------
interface ptl_in_if;
  logic                        valid;
  logic                        ready;
  logic [ptl_pkg::IdxW-1:0]    pixel_index;
  logic [ptl_pkg::SampleW-1:0] sample;
  logic                        prime;

  modport source (output valid, output pixel_index, output sample, output prime,
                  input ready);
  modport sink   (input valid, input pixel_index, input sample, input prime,
                  output ready);
endinterface

@@ hdl/ptl_out_if.sv @@
// ----------------------------------------------------------------------------
// ptl_out_if
// Result request channel: filtered 8-bit intensity.
// ----------------------------------------------------------------------------
interface ptl_out_if;
  logic                        valid;
  logic                        ready;
  logic [ptl_pkg::SampleW-1:0] filtered;

  modport source (output valid, output filtered, input ready);
  modport sink   (input valid, input filtered, output ready);
endinterface

@@ hdl/ptl_store.sv @@
// ----------------------------------------------------------------------------
// ptl_store
// Frame store: per pixel {previous input, previous output}, one write port,
// one read port with registered read data.
// ----------------------------------------------------------------------------
module ptl_store #(
  parameter int FRAME_SAMPLES = ptl_pkg::FrameSamplesDef,
  parameter int AW            = ptl_pkg::addr_width(FRAME_SAMPLES)
) (
  input  logic                       clk_i,
  input  logic                       rd_en_i,
  input  logic [AW-1:0]              rd_addr_i,
  output logic [ptl_pkg::StoreW-1:0] rd_data_o,
  input  logic                       wr_en_i,
  input  logic [AW-1:0]              wr_addr_i,
  input  logic [ptl_pkg::StoreW-1:0] wr_data_i
);

  logic [ptl_pkg::StoreW-1:0] mem [FRAME_SAMPLES];
  logic [ptl_pkg::StoreW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ hdl/ptl_regs.sv @@
// ----------------------------------------------------------------------------
// ptl_regs
// APB configuration registers: filter enable and cutoff select.
// ----------------------------------------------------------------------------
module ptl_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ptl_pkg::PAddrW-1:0] paddr,
  input  logic [ptl_pkg::PDataW-1:0] pwdata,
  output logic [ptl_pkg::PDataW-1:0] prdata,
  output logic                       pready,
  output ptl_pkg::cfg_t              cfg_o
);

  ptl_pkg::cfg_t cfg_q, cfg_d;
  logic          wr_req;
  logic          reg_idx;

  assign pready  = 1'b1;
  assign wr_req  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[2];

  always_comb begin
    cfg_d = cfg_q;
    if (wr_req) begin
      unique case (reg_idx)
        ptl_pkg::RegEnable: cfg_d.enable = pwdata[0];
        ptl_pkg::RegCutoff: cfg_d.cutoff = pwdata[ptl_pkg::CutoffW-1:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      ptl_pkg::RegEnable: prdata = ptl_pkg::PDataW'(cfg_q.enable);
      ptl_pkg::RegCutoff: prdata = ptl_pkg::PDataW'(cfg_q.cutoff);
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ hdl/ptl_datapath.sv @@
// ----------------------------------------------------------------------------
// ptl_datapath
// Read-modify-write pipeline: store read on request, products in stage 1,
// sum/saturate and store write-back in stage 2, output register.
// ----------------------------------------------------------------------------
module ptl_datapath #(
  parameter int FRAME_SAMPLES  = ptl_pkg::FrameSamplesDef,
  parameter int COEF_FRAC_BITS = ptl_pkg::CoefFracBitsDef,
  parameter int AW             = ptl_pkg::addr_width(FRAME_SAMPLES)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  ptl_pkg::cfg_t              cfg_i,
  ptl_in_if.sink                     in_i,
  ptl_out_if.source                  out_o,
  output logic                       rd_en_o,
  output logic [AW-1:0]              rd_addr_o,
  input  logic [ptl_pkg::StoreW-1:0] rd_data_i,
  output logic                       wr_en_o,
  output logic [AW-1:0]              wr_addr_o,
  output logic [ptl_pkg::StoreW-1:0] wr_data_o,
  output ptl_pkg::stat_t             stat_o
);

  localparam int F    = COEF_FRAC_BITS;
  localparam int SW   = ptl_pkg::SampleW;
  localparam int PbW  = F + SW + 1;
  localparam int PaW  = F + SW;
  localparam int AccW = F + SW + 2;

  typedef enum logic [1:0] {KindPass, KindPrime, KindFilter} kind_e;

  // coefficient tables
  logic [F-1:0] bq_tab [ptl_pkg::TableLen];
  logic [F-1:0] aq_tab [ptl_pkg::TableLen];

  for (genvar g = 0; g < ptl_pkg::TableLen; g++) begin : g_coef
    localparam logic [63:0] Bq = ptl_pkg::to_fixed(ptl_pkg::FfDec[g], F);
    localparam logic [63:0] Aq = ptl_pkg::to_fixed(ptl_pkg::FbDec[g], F);
    assign bq_tab[g] = Bq[F-1:0];
    assign aq_tab[g] = Aq[F-1:0];
  end

  // stage 1
  logic                  v1_q, fwd1_q;
  kind_e                 kind1_q;
  logic [AW-1:0]         addr1_q;
  logic [SW-1:0]         x1_q, fwdx1_q, fwdy1_q;
  // stage 2
  logic                  v2_q;
  kind_e                 kind2_q;
  logic [AW-1:0]         addr2_q;
  logic [SW-1:0]         x2_q;
  logic [PbW-1:0]        pb2_q;
  logic [PaW-1:0]        pa2_q;
  // output
  logic                  ov_q;
  logic [SW-1:0]         y_q;

  logic                  in_req, en2, en3, move1, hz;
  logic                  in_range, wr_hit_in, wr_hit1;
  kind_e                 kind_in;
  logic [AW-1:0]         addr_in;
  logic [ptl_pkg::CutoffW-1:0] sel;
  logic [SW-1:0]         xp, yp, y2;
  logic [SW:0]           xsum;
  logic [PbW-1:0]        pb_d;
  logic [PaW-1:0]        pa_d;
  logic [AccW-1:0]       acc;
  logic [AccW-F-1:0]     yraw;

  assign in_range = {5'b0, in_i.pixel_index} < ptl_pkg::IdxExtW'(FRAME_SAMPLES);
  assign addr_in  = AW'(in_i.pixel_index);

  always_comb begin
    if (!cfg_i.enable || !in_range) begin
      kind_in = KindPass;
    end else if (in_i.prime) begin
      kind_in = KindPrime;
    end else begin
      kind_in = KindFilter;
    end
  end

  // flow control
  assign en3    = !ov_q || out_o.ready;
  assign en2    = !v2_q || en3;
  assign hz     = v1_q && (kind1_q == KindFilter) && v2_q && (kind2_q != KindPass)
                  && (addr2_q == addr1_q);
  assign move1  = v1_q && !hz && en2;
  assign in_i.ready = !v1_q || move1;
  assign in_req = in_i.valid && in_i.ready;

  assign rd_en_o   = in_req && (kind_in == KindFilter);
  assign rd_addr_o = addr_in;

  // write-back as stage 2 drains
  assign wr_en_o   = v2_q && en3 && (kind2_q != KindPass);
  assign wr_addr_o = addr2_q;
  assign wr_data_o = {x2_q, y2};

  assign wr_hit_in = wr_en_o && (wr_addr_o == addr_in);
  assign wr_hit1   = wr_en_o && (wr_addr_o == addr1_q);

  // stage 1 operands, newest write wins over store data
  assign xp   = fwd1_q ? fwdx1_q : rd_data_i[ptl_pkg::StoreW-1:SW];
  assign yp   = fwd1_q ? fwdy1_q : rd_data_i[SW-1:0];
  assign sel  = (cfg_i.cutoff > ptl_pkg::CutoffMax) ? ptl_pkg::CutoffMax : cfg_i.cutoff;
  assign xsum = {1'b0, x1_q} + {1'b0, xp};
  assign pb_d = PbW'(bq_tab[sel]) * PbW'(xsum);
  assign pa_d = PaW'(aq_tab[sel]) * PaW'(yp);

  // stage 2 sum, truncate, saturate
  assign acc  = AccW'(pb2_q) + AccW'(pa2_q);
  assign yraw = acc[AccW-1:F];

  always_comb begin
    if (kind2_q != KindFilter) begin
      y2 = x2_q;
    end else if (yraw > (AccW-F)'(ptl_pkg::SampleMax)) begin
      y2 = ptl_pkg::SampleMax;
    end else begin
      y2 = yraw[SW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      fwd1_q <= 1'b0;
      v2_q   <= 1'b0;
      ov_q   <= 1'b0;
    end else begin
      if (in_req) begin
        v1_q   <= 1'b1;
        fwd1_q <= wr_hit_in;
      end else if (move1) begin
        v1_q <= 1'b0;
      end else if (v1_q && wr_hit1) begin
        fwd1_q <= 1'b1;
      end
      if (en2) begin
        v2_q <= move1;
      end
      if (en3) begin
        ov_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_req) begin
      kind1_q <= kind_in;
      addr1_q <= addr_in;
      x1_q    <= in_i.sample;
      fwdx1_q <= wr_data_o[ptl_pkg::StoreW-1:SW];
      fwdy1_q <= wr_data_o[SW-1:0];
    end else if (v1_q && !move1 && wr_hit1) begin
      fwdx1_q <= wr_data_o[ptl_pkg::StoreW-1:SW];
      fwdy1_q <= wr_data_o[SW-1:0];
    end
    if (move1) begin
      kind2_q <= kind1_q;
      addr2_q <= addr1_q;
      x2_q    <= x1_q;
      pb2_q   <= pb_d;
      pa2_q   <= pa_d;
    end
    if (en3 && v2_q) begin
      y_q <= y2;
    end
  end

  assign out_o.valid    = ov_q;
  assign out_o.filtered = y_q;

  assign stat_o.s1_valid = v1_q;
  assign stat_o.s2_valid = v2_q;
  assign stat_o.hazard   = hz;
  assign stat_o.store_wr = wr_en_o;

endmodule

@@ hdl/pixel_temporal_lowpass.sv @@
// ----------------------------------------------------------------------------
// pixel_temporal_lowpass
// Per-pixel first-order Butterworth temporal low-pass over a sample stream.
// ----------------------------------------------------------------------------
// The block takes one sample request per clock while stage 1 is not held by
// output back-pressure or a same-pixel hazard, and returns one filtered
// sample per request, in order. Both per-pixel histories (previous input,
// previous output) sit in one FRAME_SAMPLES x 16 single-write, single-read
// memory read when a filter request is accepted and written back as it
// leaves the second stage. A filter request right behind a primed or
// filtered request for the same pixel waits in stage 1 for its write-back.
// The memory holds no defined contents after reset and needs no clearing
// pass; prime a pixel before filtering it.
// ----------------------------------------------------------------------------
`include "pixel_temporal_lowpass_assert.svh"

module pixel_temporal_lowpass #(
  parameter int FRAME_SAMPLES  = ptl_pkg::FrameSamplesDef,
  parameter int COEF_FRAC_BITS = ptl_pkg::CoefFracBitsDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  ptl_in_if.sink                     in_i,
  ptl_out_if.source                  out_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ptl_pkg::PAddrW-1:0] paddr,
  input  logic [ptl_pkg::PDataW-1:0] pwdata,
  output logic [ptl_pkg::PDataW-1:0] prdata,
  output logic                       pready
);

  localparam int AW = ptl_pkg::addr_width(FRAME_SAMPLES);

  ptl_pkg::cfg_t              cfg;
  ptl_pkg::stat_t             stat;
  logic                       rd_en, wr_en;
  logic [AW-1:0]              rd_addr, wr_addr;
  logic [ptl_pkg::StoreW-1:0] rd_data, wr_data;

  ptl_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ptl_store #(
    .FRAME_SAMPLES (FRAME_SAMPLES),
    .AW            (AW)
  ) u_store (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  ptl_datapath #(
    .FRAME_SAMPLES  (FRAME_SAMPLES),
    .COEF_FRAC_BITS (COEF_FRAC_BITS),
    .AW             (AW)
  ) u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .in_i      (in_i),
    .out_o     (out_o),
    .rd_en_o   (rd_en),
    .rd_addr_o (rd_addr),
    .rd_data_i (rd_data),
    .wr_en_o   (wr_en),
    .wr_addr_o (wr_addr),
    .wr_data_o (wr_data),
    .stat_o    (stat)
  );

  `PTL_ASSERT_NOW(a_wr_from_s2, stat.store_wr,
                  stat.s2_valid && (!out_o.valid || out_o.ready))
  `PTL_ASSERT_NOW(a_hz_pair, stat.hazard, stat.s1_valid && stat.s2_valid && !in_i.ready)
  `PTL_ASSERT_NEXT(a_hz_clears, stat.hazard && (!out_o.valid || out_o.ready),
                   !stat.hazard)

endmodule
